// ===== rtl/stfl_pkg.sv =====
// ============================================================================
// stfl_pkg
// Shared types, constants and helpers for the slot table with free list.
// ============================================================================
`default_nettype none

package stfl_pkg;

    // Table geometry. Slot indexes are 12 bits wide, so at most 4096 slots.
    localparam int TABLE_DEPTH = 4096;
    localparam int FIRST_INDEX = 1;
    localparam int IDX_W       = 12;
    localparam int MARK_W      = IDX_W + 1;
    localparam int WORD_W      = 64;
    localparam int LIMIT       = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
    localparam int MEM_AW      = $clog2(LIMIT);

    // Stream payload widths.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    localparam logic [MARK_W-1:0] LIMIT_MARK = MARK_W'(LIMIT);
    localparam logic [MARK_W-1:0] MARK_RESET = MARK_W'(FIRST_INDEX);
    localparam logic [MEM_AW-1:0] CLR_LAST   = MEM_AW'(LIMIT - 1);

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_SET    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_READ   = 2'd3
    } req_e_t;

    // Status codes.
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_e_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_e_t;

    // One finished request, handed from the controller to the output register.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  assigned_index;
        logic [WORD_W-1:0] read_word;
        status_e_t         status;
    } result_t;

    // Decode a stored word as a free link: odd words carry the next index.
    function automatic logic [IDX_W-1:0] link_target(input logic [WORD_W-1:0] word);
        logic [IDX_W-1:0] nxt;
        nxt = word[IDX_W:1];
        if (!word[0] || ({1'b0, nxt} >= LIMIT_MARK))
        begin
            return '0;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slot_table_free_list_top.sv =====
// ============================================================================
// slot_table_free_list_top
// Fixed table of 64-bit entries with a high-water mark and a free chain
// threaded through freed entries; add, set, remove and read requests.
// ============================================================================
//
//  Channel | Dir | Payload
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tuser: req_type; tdata: slot_index, entry_value
//  m_*     | out | tuser: status;   tdata: assigned_index, read_word
//
//  Each request first reads the head or addressed entry from the synchronous
//  table memory, then decides the result and writes the entry back.
//  After reset a clearing pass zeroes all LIMIT entries (4096 at the default
//  depth), one entry per cycle; s_tready stays low meanwhile.
//  A finished result waits in an output register; the next request is taken
//  meanwhile and stalls in execution only while that register is still full.
//
`default_nettype none

module slot_table_free_list_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Request stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [stfl_pkg::S_TDATA_W-1:0]   s_tdata,  // [11:0] slot_index, [75:12] entry_value
    input  wire logic [1:0]                       s_tuser,  // [1:0] req_type
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [stfl_pkg::M_TDATA_W-1:0]        m_tdata,  // [11:0] assigned_index, [75:12] read_word
    output logic [1:0]                            m_tuser   // [1:0] status
);

    localparam int VAL_LO = stfl_pkg::IDX_W;
    localparam int VAL_HI = stfl_pkg::IDX_W + stfl_pkg::WORD_W - 1;
    localparam int PAD_W  = stfl_pkg::M_TDATA_W - stfl_pkg::IDX_W - stfl_pkg::WORD_W;

    stfl_pkg::result_t                res;
    logic                             out_free;
    logic                             m_valid_reg, m_valid_next;
    logic [stfl_pkg::IDX_W-1:0]       index_reg, index_next;
    logic [stfl_pkg::WORD_W-1:0]      word_reg, word_next;
    stfl_pkg::status_e_t              status_reg, status_next;

    logic                             ram_wr_en;
    logic [stfl_pkg::MEM_AW-1:0]      ram_wr_addr;
    logic [stfl_pkg::WORD_W-1:0]      ram_wr_data;
    logic                             ram_rd_en;
    logic [stfl_pkg::MEM_AW-1:0]      ram_rd_addr;
    logic [stfl_pkg::WORD_W-1:0]      ram_rd_data;

    // Request sequencer.
    stfl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_req_type    (stfl_pkg::req_e_t'(s_tuser)),
        .in_slot_index  (s_tdata[stfl_pkg::IDX_W-1:0]),
        .in_entry_value (s_tdata[VAL_HI:VAL_LO]),
        .out_free       (out_free),
        .res            (res),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    // Entry table.
    stfl_ram #(
        .WIDTH (stfl_pkg::WORD_W),
        .DEPTH (stfl_pkg::LIMIT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        index_next   = index_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        if (res.valid)
        begin
            m_valid_next = 1'b1;
            index_next   = res.assigned_index;
            word_next    = res.read_word;
            status_next  = res.status;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg  <= index_next;
        word_reg   <= word_next;
        status_reg <= status_next;
    end

    // Result stream packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, word_reg, index_reg};
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

// ===== rtl/stfl_ram.sv =====
// ============================================================================
// stfl_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data when not enabled.
// ============================================================================
`default_nettype none

module stfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stfl_ctrl.sv =====
// ============================================================================
// stfl_ctrl
// Request sequencer: clears the table after reset, reads the addressed or
// head entry, then decides the result and writes the entry back.
// ============================================================================
`default_nettype none

module stfl_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request side
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire stfl_pkg::req_e_t              in_req_type,
    input  wire logic [stfl_pkg::IDX_W-1:0]    in_slot_index,
    input  wire logic [stfl_pkg::WORD_W-1:0]   in_entry_value,
    // Result side
    input  wire logic                          out_free,
    output stfl_pkg::result_t                  res,
    // Table memory
    output logic                               ram_wr_en,
    output logic [stfl_pkg::MEM_AW-1:0]        ram_wr_addr,
    output logic [stfl_pkg::WORD_W-1:0]        ram_wr_data,
    output logic                               ram_rd_en,
    output logic [stfl_pkg::MEM_AW-1:0]        ram_rd_addr,
    input  wire logic [stfl_pkg::WORD_W-1:0]   ram_rd_data
);

    stfl_pkg::state_e_t                state_reg, state_next;
    logic [stfl_pkg::MEM_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    stfl_pkg::req_e_t                  req_reg, req_next;
    logic [stfl_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [stfl_pkg::WORD_W-1:0]       val_reg, val_next;
    logic [stfl_pkg::MARK_W-1:0]       hw_reg, hw_next;
    logic [stfl_pkg::IDX_W-1:0]        head_reg, head_next;

    logic                              accept;
    logic                              complete;

    // Decisions of the request being executed.
    logic                              idx_in_range;
    logic                              head_ok;
    logic                              mark_ok;
    logic                              ex_wr_en;
    logic [stfl_pkg::MEM_AW-1:0]       ex_wr_addr;
    logic [stfl_pkg::WORD_W-1:0]       ex_wr_data;
    logic [stfl_pkg::MARK_W-1:0]       ex_hw;
    logic [stfl_pkg::IDX_W-1:0]        ex_head;
    logic [stfl_pkg::IDX_W-1:0]        ex_index;
    logic [stfl_pkg::WORD_W-1:0]       ex_word;
    stfl_pkg::status_e_t               ex_status;

    assign accept   = (state_reg == stfl_pkg::ST_IDLE) && in_valid;
    assign complete = (state_reg == stfl_pkg::ST_EXEC) && out_free;

    // Execute-stage decision, using the entry read when the request was accepted.
    always_comb
    begin
        idx_in_range = (idx_reg != '0) && ({1'b0, idx_reg} < stfl_pkg::LIMIT_MARK);
        head_ok      = (head_reg != '0) && ({1'b0, head_reg} < stfl_pkg::LIMIT_MARK);
        mark_ok      = (hw_reg != '0) && (hw_reg < stfl_pkg::LIMIT_MARK);
        ex_wr_en     = 1'b0;
        ex_wr_addr   = idx_reg[stfl_pkg::MEM_AW-1:0];
        ex_wr_data   = val_reg;
        ex_hw        = hw_reg;
        ex_head      = head_reg;
        ex_index     = idx_reg;
        ex_word      = '0;
        ex_status    = stfl_pkg::STAT_OK;
        case (req_reg)
            stfl_pkg::REQ_ADD:
            begin
                if (head_ok)
                begin
                    ex_wr_en   = 1'b1;
                    ex_wr_addr = head_reg[stfl_pkg::MEM_AW-1:0];
                    ex_head    = stfl_pkg::link_target(ram_rd_data);
                    ex_index   = head_reg;
                end
                else if (mark_ok)
                begin
                    ex_wr_en   = 1'b1;
                    ex_wr_addr = hw_reg[stfl_pkg::MEM_AW-1:0];
                    ex_hw      = hw_reg + stfl_pkg::MARK_W'(1);
                    ex_index   = hw_reg[stfl_pkg::IDX_W-1:0];
                end
                else
                begin
                    ex_index  = '0;
                    ex_status = stfl_pkg::STAT_FULL;
                end
            end
            stfl_pkg::REQ_SET:
            begin
                if (idx_in_range)
                begin
                    ex_wr_en = 1'b1;
                    if ({1'b0, idx_reg} >= hw_reg)
                    begin
                        ex_hw = {1'b0, idx_reg} + stfl_pkg::MARK_W'(1);
                    end
                end
                else
                begin
                    ex_status = stfl_pkg::STAT_BAD;
                end
            end
            stfl_pkg::REQ_REMOVE:
            begin
                if (idx_in_range && ({1'b0, idx_reg} < hw_reg))
                begin
                    ex_wr_en   = 1'b1;
                    ex_wr_data = {{(stfl_pkg::WORD_W - stfl_pkg::IDX_W - 1){1'b0}},
                                  head_reg, 1'b1};
                    ex_head    = idx_reg;
                end
                else
                begin
                    ex_status = stfl_pkg::STAT_BAD;
                end
            end
            stfl_pkg::REQ_READ:
            begin
                if (idx_in_range)
                begin
                    ex_word = ram_rd_data;
                end
                else
                begin
                    ex_status = stfl_pkg::STAT_BAD;
                end
            end
            default:
            begin
                ex_status = stfl_pkg::STAT_BAD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stfl_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == stfl_pkg::CLR_LAST)
                begin
                    state_next = stfl_pkg::ST_IDLE;
                end
            end
            stfl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stfl_pkg::ST_EXEC;
                end
            end
            stfl_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = stfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stfl_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs and memory port control.
    always_comb
    begin
        in_ready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = ex_wr_addr;
        ram_wr_data = ex_wr_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = in_slot_index[stfl_pkg::MEM_AW-1:0];
        case (state_reg)
            stfl_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = '0;
            end
            stfl_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ram_rd_en = in_valid;
                if (in_req_type == stfl_pkg::REQ_ADD)
                begin
                    ram_rd_addr = head_reg[stfl_pkg::MEM_AW-1:0];
                end
            end
            stfl_pkg::ST_EXEC:
            begin
                ram_wr_en = ex_wr_en && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        res.valid          = complete;
        res.assigned_index = ex_index;
        res.read_word      = ex_word;
        res.status         = ex_status;
    end

    // Register updates.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        hw_next      = hw_reg;
        head_next    = head_reg;
        if (state_reg == stfl_pkg::ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + stfl_pkg::MEM_AW'(1);
        end
        if (accept)
        begin
            req_next = in_req_type;
            idx_next = in_slot_index;
            val_next = in_entry_value;
        end
        if (complete)
        begin
            hw_next   = ex_hw;
            head_next = ex_head;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stfl_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            hw_reg      <= stfl_pkg::MARK_RESET;
            head_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hw_reg      <= hw_next;
            head_reg    <= head_next;
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

`ifndef SYNTH
    // An accepted request always moves on to execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == stfl_pkg::ST_EXEC))
        else $error("accepted request did not enter execution");

    // The high-water mark never moves down.
    a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hw_reg >= $past(hw_reg)))
        else $error("high-water mark decreased");

    // The table is only written by the clearing pass or a finishing request.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == stfl_pkg::ST_CLEAR) || complete))
        else $error("table written outside clear or completion");

    // A result is only produced when the output register can take it.
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result produced while output register busy");

    // The table is only read while a request is being accepted.
    a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (state_reg == stfl_pkg::ST_IDLE))
        else $error("table read outside the idle state");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the slot table with free list. A queue of requests
// (directed cases first, then random traffic in two phases: a low mark that
// grows, and a table whose mark has hit the top so that only the free chain
// can serve an add) feeds a bursty stream driver. A shadow copy of the
// table, mark and chain head predicts each result as the transaction is
// accepted, and a monitor compares the results field by field under a
// randomly stalling receiver.
// ============================================================================
`default_nettype none

module tb_top;

    // One queued request; a drain point holds the stream until all results are in.
    typedef struct {
        logic                        drain_point;
        stfl_pkg::req_e_t            kind;
        logic [stfl_pkg::IDX_W-1:0]  idx;
        logic [stfl_pkg::WORD_W-1:0] value;
    } request_t;

    // One predicted result.
    typedef struct {
        logic [stfl_pkg::IDX_W-1:0]  index;
        logic [stfl_pkg::WORD_W-1:0] word;
        stfl_pkg::status_e_t         status;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [stfl_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]                     s_tuser  = stfl_pkg::REQ_ADD;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [stfl_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                     m_tuser;

    // Shadow of the block state.
    logic [stfl_pkg::WORD_W-1:0] shadow_words [stfl_pkg::LIMIT];
    logic [stfl_pkg::MARK_W-1:0] shadow_mark;
    logic [stfl_pkg::IDX_W-1:0]  shadow_head;

    request_t request_queue [$];
    outcome_t expected_results [$];
    request_t on_bus;
    outcome_t oldest;
    int       failures = 0;
    int       gen_mark = stfl_pkg::FIRST_INDEX;

    // Driver pacing.
    int   burst_left = 0;
    int   gap_left   = 0;
    logic go_valid;

    // Receiver stall pattern.
    logic [15:0] ready_pattern    = 16'hFFFF;
    int          ready_phase_left = 0;

    always #5 clk = ~clk;

    slot_table_free_list_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [11:0] slot_index, [75:12] entry_value
        .s_tuser  (s_tuser),   // [1:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [11:0] assigned_index, [75:12] read_word
        .m_tuser  (m_tuser)    // [1:0] status
    );

    // Apply one request to the shadow state and return the result it gives.
    function automatic outcome_t apply_request(request_t r);
        outcome_t                    o;
        logic [stfl_pkg::IDX_W-1:0]  slot;
        logic [stfl_pkg::IDX_W-1:0]  next_link;
        logic [stfl_pkg::WORD_W-1:0] held;
        o.index  = r.idx;
        o.word   = '0;
        o.status = stfl_pkg::STAT_OK;
        case (r.kind)
            stfl_pkg::REQ_ADD:
            begin
                if (shadow_head != '0 && int'(shadow_head) < stfl_pkg::LIMIT)
                begin
                    // Pop the chain; an even word or an out-of-range link ends it.
                    slot      = shadow_head;
                    held      = shadow_words[slot];
                    next_link = held[stfl_pkg::IDX_W:1];
                    if (!held[0] || int'(next_link) >= stfl_pkg::LIMIT)
                    begin
                        next_link = '0;
                    end
                    shadow_head        = next_link;
                    shadow_words[slot] = r.value;
                    o.index            = slot;
                end
                else if (int'(shadow_mark) < stfl_pkg::LIMIT && shadow_mark != '0)
                begin
                    slot               = shadow_mark[stfl_pkg::IDX_W-1:0];
                    shadow_words[slot] = r.value;
                    shadow_mark        = shadow_mark + 1'b1;
                    o.index            = slot;
                end
                else
                begin
                    o.index  = '0;
                    o.status = stfl_pkg::STAT_FULL;
                end
            end
            stfl_pkg::REQ_SET:
            begin
                if (r.idx == '0 || int'(r.idx) >= stfl_pkg::LIMIT)
                begin
                    o.status = stfl_pkg::STAT_BAD;
                end
                else
                begin
                    shadow_words[r.idx] = r.value;
                    if ({1'b0, r.idx} >= shadow_mark)
                    begin
                        shadow_mark = {1'b0, r.idx} + 1'b1;
                    end
                end
            end
            stfl_pkg::REQ_REMOVE:
            begin
                if (r.idx == '0 || {1'b0, r.idx} >= shadow_mark
                    || int'(r.idx) >= stfl_pkg::LIMIT)
                begin
                    o.status = stfl_pkg::STAT_BAD;
                end
                else
                begin
                    shadow_words[r.idx] = stfl_pkg::WORD_W'({shadow_head, 1'b1});
                    shadow_head         = r.idx;
                end
            end
            default:
            begin
                if (r.idx == '0 || int'(r.idx) >= stfl_pkg::LIMIT)
                begin
                    o.status = stfl_pkg::STAT_BAD;
                end
                else
                begin
                    o.word = shadow_words[r.idx];
                end
            end
        endcase
        return o;
    endfunction

    // Queue a request and keep a rough upper bound of the mark for index choice.
    function automatic void push_request(stfl_pkg::req_e_t kind, int idx,
                                         logic [stfl_pkg::WORD_W-1:0] value);
        request_t r;
        r.drain_point = 1'b0;
        r.kind        = kind;
        r.idx         = stfl_pkg::IDX_W'(idx);
        r.value       = value;
        request_queue.push_back(r);
        if (kind == stfl_pkg::REQ_ADD && gen_mark < stfl_pkg::LIMIT)
        begin
            gen_mark++;
        end
        else if (kind == stfl_pkg::REQ_SET && idx != 0 && idx + 1 > gen_mark)
        begin
            gen_mark = idx + 1;
        end
    endfunction

    function automatic void push_drain_point();
        request_t r;
        r.drain_point = 1'b1;
        r.kind        = stfl_pkg::REQ_READ;
        r.idx         = '0;
        r.value       = '0;
        request_queue.push_back(r);
    endfunction

    // Mostly plain random words, sometimes an odd word that forges a chain link.
    function automatic logic [stfl_pkg::WORD_W-1:0] random_word();
        if ($urandom_range(0, 9) == 0)
        begin
            return (64'($urandom_range(0, stfl_pkg::LIMIT - 1)) << 1) | 64'd1;
        end
        return {$urandom, $urandom};
    endfunction

    // Indexes cluster below the mark so that most requests hit live slots.
    function automatic int random_index();
        int top;
        top = (gen_mark < stfl_pkg::LIMIT) ? gen_mark : stfl_pkg::LIMIT - 1;
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(0, top);
        end
        return $urandom_range(0, (1 << stfl_pkg::IDX_W) - 1);
    endfunction

    function automatic void push_random_request(bit grow_phase);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            push_request(stfl_pkg::REQ_ADD, $urandom_range(0, (1 << stfl_pkg::IDX_W) - 1),
                         random_word());
        end
        else if (pick < 60)
        begin
            push_request(stfl_pkg::REQ_REMOVE, random_index(), '0 | {$urandom, $urandom});
        end
        else if (pick < 75)
        begin
            // While the mark grows, sets land at most just above it so the table fills slowly.
            if (grow_phase)
            begin
                idx = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, gen_mark + 3);
                if (idx >= stfl_pkg::LIMIT)
                begin
                    idx = stfl_pkg::LIMIT - 1;
                end
            end
            else
            begin
                idx = random_index();
            end
            push_request(stfl_pkg::REQ_SET, idx, random_word());
        end
        else
        begin
            push_request(stfl_pkg::REQ_READ, random_index(), {$urandom, $urandom});
        end
    endfunction

    // Stream driver: bursts of transactions separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            go_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(on_bus));
                go_valid = 1'b0;
            end
            if (!go_valid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (request_queue.size() != 0)
                begin
                    if (request_queue[0].drain_point)
                    begin
                        if (expected_results.size() == 0)
                        begin
                            void'(request_queue.pop_front());
                        end
                    end
                    else
                    begin
                        on_bus   = request_queue.pop_front();
                        go_valid = 1'b1;
                        s_tuser <= on_bus.kind;
                        s_tdata <= stfl_pkg::S_TDATA_W'({on_bus.value, on_bus.idx});
                        if (burst_left <= 1)
                        begin
                            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                                     : $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                        else
                        begin
                            burst_left--;
                        end
                    end
                end
            end
            s_tvalid <= go_valid;
        end
    end

    // Receiver: rotate a stall pattern, redrawing the pattern and its phase length at random.
    always @(posedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_phase_left <= $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom);
                2:       ready_pattern <= 16'h0101;
                default: ready_pattern <= 16'($urandom) | 16'($urandom);
            endcase
        end
        else
        begin
            ready_phase_left <= ready_phase_left - 1;
            ready_pattern    <= {ready_pattern[14:0], ready_pattern[15]};
        end
        m_tready <= ready_pattern[0];
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                failures++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (m_tdata[stfl_pkg::IDX_W-1:0] !== oldest.index)
                begin
                    $error("assigned_index: expected %0d, got %0d", oldest.index,
                           m_tdata[stfl_pkg::IDX_W-1:0]);
                    failures++;
                end
                if (m_tdata[stfl_pkg::IDX_W+stfl_pkg::WORD_W-1:stfl_pkg::IDX_W] !== oldest.word)
                begin
                    $error("read_word: expected %h, got %h", oldest.word,
                           m_tdata[stfl_pkg::IDX_W+stfl_pkg::WORD_W-1:stfl_pkg::IDX_W]);
                    failures++;
                end
                if (m_tuser !== oldest.status)
                begin
                    $error("status: expected %0d, got %0d", oldest.status, m_tuser);
                    failures++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        for (int i = 0; i < stfl_pkg::LIMIT; i++)
        begin
            shadow_words[i] = '0;
        end
        shadow_mark = stfl_pkg::MARK_W'(stfl_pkg::FIRST_INDEX);
        shadow_head = '0;

        // Directed: bad indexes, the field extremes, chain reuse and its corner cases.
        push_request(stfl_pkg::REQ_READ, 0, '1);
        push_request(stfl_pkg::REQ_READ, stfl_pkg::LIMIT - 1, '0);
        push_request(stfl_pkg::REQ_ADD, (1 << stfl_pkg::IDX_W) - 1, '1);
        push_request(stfl_pkg::REQ_ADD, 0, '0);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h5555_5555_5555_5550);
        push_request(stfl_pkg::REQ_SET, 0, 64'hAAAA_AAAA_AAAA_AAA0);
        push_request(stfl_pkg::REQ_REMOVE, 0, '0);
        push_request(stfl_pkg::REQ_REMOVE, 4, '0);
        push_request(stfl_pkg::REQ_REMOVE, 2, '0);
        push_request(stfl_pkg::REQ_REMOVE, 1, '0);
        push_request(stfl_pkg::REQ_READ, 1, '0);
        // A set over a freed entry breaks the chain behind it.
        push_request(stfl_pkg::REQ_SET, 2, 64'h0000_0000_0000_0040);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h1234_5678_9ABC_DEF0);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h0FED_CBA9_8765_4320);
        // Removing the same slot twice makes it link to itself.
        push_request(stfl_pkg::REQ_REMOVE, 3, '0);
        push_request(stfl_pkg::REQ_REMOVE, 3, '0);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h8000_0000_0000_0000);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h7FFF_FFFF_FFFF_FFF0);
        push_request(stfl_pkg::REQ_SET, 10, 64'hFFFF_FFFF_FFFF_FFF0);
        // A forged odd word redirects the chain.
        push_request(stfl_pkg::REQ_REMOVE, 5, '0);
        push_request(stfl_pkg::REQ_SET, 5, (64'd9 << 1) | 64'd1);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h0000_0000_0000_0010);
        push_request(stfl_pkg::REQ_ADD, 0, 64'h0000_0000_0000_0020);
        push_request(stfl_pkg::REQ_READ, 9, '0);
        push_drain_point();

        // Random traffic while the mark still grows.
        for (int n = 0; n < 950; n++)
        begin
            if (n == 475)
            begin
                push_drain_point();
            end
            push_random_request(1'b1);
        end
        push_drain_point();

        // Push the mark to the top; from here on only the chain serves an add.
        push_request(stfl_pkg::REQ_SET, stfl_pkg::LIMIT - 1, 64'hC0DE_C0DE_C0DE_C0D0);
        push_request(stfl_pkg::REQ_READ, stfl_pkg::LIMIT - 1, '0);
        for (int n = 0; n < 950; n++)
        begin
            push_random_request(1'b0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (20) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/stfl_pkg.sv
rtl/stfl_ram.sv
rtl/stfl_ctrl.sv
rtl/slot_table_free_list_top.sv
sim/tb_top.sv
